// ----- design/mb2_pkg.sv -----
`default_nettype none

package mb2_pkg;

   typedef enum logic [1:0] {
      KIND_MAP    = 2'd0,
      KIND_NAME   = 2'd1,
      KIND_FINISH = 2'd2
   } kind_type;

   // tag type codes
   localparam logic [31:0] TAG_END         = 32'd0;
   localparam logic [31:0] TAG_NAME        = 32'd2;
   localparam logic [31:0] TAG_BOOT_MODULE = 32'd3;
   localparam logic [31:0] TAG_MEMORY_MAP  = 32'd6;

   // byte offsets
   localparam logic [31:0] WORD_BYTES      = 32'd4;
   localparam logic [31:0] FIRST_TAG       = 32'd8;
   localparam logic [31:0] REL_TYPE        = 32'd0;
   localparam logic [31:0] REL_SIZE        = 32'd4;
   localparam logic [31:0] REL_BODY        = 32'd8;
   localparam logic [31:0] REL_ENTRIES     = 32'd16;
   localparam logic [31:0] MIN_TAG_BYTES   = 32'd8;
   localparam logic [31:0] MIN_STRIDE      = 32'd24;
   localparam logic [32:0] ENTRY_TAIL      = 33'd8;
   localparam logic [32:0] ALIGN_MASK      = 33'd7;

   // word positions inside one map entry
   localparam logic [31:0] EW_BASE_LO = 32'd0;
   localparam logic [31:0] EW_BASE_HI = 32'd4;
   localparam logic [31:0] EW_LEN_LO  = 32'd8;
   localparam logic [31:0] EW_LEN_HI  = 32'd12;
   localparam logic [31:0] EW_TYPE    = 32'd16;

   // map entry types and the kinds they become
   localparam logic [31:0] MT_AVAILABLE = 32'd1;
   localparam logic [31:0] MT_ACPI_RECL = 32'd3;
   localparam logic [31:0] MT_ACPI_NVS  = 32'd4;
   localparam logic [31:0] MT_BAD_RAM   = 32'd5;
   localparam logic [2:0]  MK_AVAILABLE = 3'd0;
   localparam logic [2:0]  MK_ACPI_RECL = 3'd1;
   localparam logic [2:0]  MK_ACPI_NVS  = 3'd2;
   localparam logic [2:0]  MK_BAD_RAM   = 3'd3;
   localparam logic [2:0]  MK_RESERVED  = 3'd4;

   // power of two, pointers wrap on their own
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // all results caused by one word
   typedef struct packed {
      logic [2:0]      name_cnt;
      logic [3:0][7:0] name_chars;
      logic [5:0]      name_pos;
      logic            map_vld;
      logic [63:0]     region_base;
      logic [63:0]     region_length;
      logic [2:0]      mem_kind;
      logic [4:0]      entry_index;
      logic            fin;
      logic [31:0]     kernel_addr;
      logic [5:0]      entry_count;
   } batch_type;

   function automatic logic [2:0] map_kind(input logic [31:0] mem_type);
      logic [2:0] k;
      k = MK_RESERVED;
      if (mem_type == MT_AVAILABLE) k = MK_AVAILABLE;
      if (mem_type == MT_ACPI_RECL) k = MK_ACPI_RECL;
      if (mem_type == MT_ACPI_NVS)  k = MK_ACPI_NVS;
      if (mem_type == MT_BAD_RAM)   k = MK_BAD_RAM;
      return k;
   endfunction

endpackage

`default_nettype wire

// ----- design/mb2_req_if.sv -----
`default_nettype none

interface mb2_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic        start_of_info;

   modport source (output valid, output data_word, output start_of_info, input ready);
   modport sink (input valid, input data_word, input start_of_info, output ready);
endinterface

`default_nettype wire

// ----- design/mb2_rsp_if.sv -----
`default_nettype none

interface mb2_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] region_base;
   logic [63:0] region_length;
   logic [2:0]  mem_kind;
   logic [4:0]  entry_index;
   logic [7:0]  name_char;
   logic [5:0]  name_pos;
   logic [31:0] kernel_addr;
   logic [5:0]  entry_count;
   logic        run_last;

   modport source (output valid, output kind, output region_base, output region_length,
                   output mem_kind, output entry_index, output name_char, output name_pos,
                   output kernel_addr, output entry_count, output run_last, input ready);
   modport sink (input valid, input kind, input region_base, input region_length,
                 input mem_kind, input entry_index, input name_char, input name_pos,
                 input kernel_addr, input entry_count, input run_last, output ready);
endinterface

`default_nettype wire

// ----- design/mb2_front.sv -----
`default_nettype none

module mb2_front #(
   parameter int MAX_MAP_ENTRIES = 32,
   parameter int NAME_MAX_BYTES  = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   mb2_req_if.sink           req,
   output logic              push,
   output mb2_pkg::batch_type push_data,
   input  wire logic         full
);
   import mb2_pkg::*;

   localparam logic [5:0] MAP_LIMIT  = 6'(MAX_MAP_ENTRIES);
   localparam logic [5:0] NAME_LIMIT = 6'(NAME_MAX_BYTES - 1);

   logic        accept;
   logic [31:0] w;

   logic        active_ff, active_in;
   logic [31:0] word_offset_ff, word_offset_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] tag_begin_ff, tag_begin_in;
   logic [31:0] tag_code_ff, tag_code_in;
   logic [31:0] tag_bytes_ff, tag_bytes_in;
   logic [31:0] stride_ff, stride_in;
   logic [31:0] entry_word_ff, entry_word_in;
   logic [63:0] base_acc_ff, base_acc_in;
   logic [63:0] length_acc_ff, length_acc_in;
   logic [5:0]  stored_ff, stored_in;
   logic [5:0]  name_len_ff, name_len_in;
   logic        stopped_ff, stopped_in;
   logic [31:0] module_addr_ff, module_addr_in;

   logic [32:0] span;
   logic        in_tag, advance, in_body;
   logic [31:0] rel_raw, rel, entry_word_nx;
   logic [32:0] next_off;
   logic        fin;

   // name scan of the four bytes of this word
   logic            scan_done, scan_stop;
   logic [5:0]      scan_len;
   logic [2:0]      scan_cnt;
   logic [3:0][7:0] scan_chars;

   assign w          = req.data_word;
   assign req.ready  = !full;
   assign accept     = req.valid && req.ready;

   assign span     = ({1'b0, tag_bytes_ff} + ALIGN_MASK) & ~ALIGN_MASK;
   assign in_tag   = word_offset_ff >= tag_begin_ff;
   assign rel_raw  = word_offset_ff - tag_begin_ff;
   assign advance  = in_tag && (rel_raw >= REL_BODY) && ({1'b0, rel_raw} >= span);
   assign rel      = advance ? rel_raw - span[31:0] : rel_raw;
   assign in_body  = in_tag && (rel >= REL_BODY) && (rel < tag_bytes_ff);
   assign next_off = {1'b0, word_offset_ff} + {1'b0, WORD_BYTES};
   assign entry_word_nx = entry_word_ff + WORD_BYTES;

   always_comb begin
      scan_done  = 1'b0;
      scan_stop  = stopped_ff;
      scan_len   = name_len_ff;
      scan_cnt   = '0;
      scan_chars = '0;
      for (int b = 0; b < 4; b++) begin
         if (!scan_done) begin
            if (({1'b0, rel} + 33'(b) >= {1'b0, tag_bytes_ff}) || scan_stop) begin
               scan_done = 1'b1;
            end else if (w[8*b +: 8] == 8'd0 || scan_len >= NAME_LIMIT) begin
               scan_stop = 1'b1;
            end else begin
               scan_chars[scan_cnt[1:0]] = w[8*b +: 8];
               scan_cnt = scan_cnt + 3'd1;
               scan_len = scan_len + 6'd1;
            end
         end
      end
   end

   always_comb begin
      active_in      = active_ff;
      word_offset_in = word_offset_ff;
      total_in       = total_ff;
      tag_begin_in   = tag_begin_ff;
      tag_code_in    = tag_code_ff;
      tag_bytes_in   = tag_bytes_ff;
      stride_in      = stride_ff;
      entry_word_in  = entry_word_ff;
      base_acc_in    = base_acc_ff;
      length_acc_in  = length_acc_ff;
      stored_in      = stored_ff;
      name_len_in    = name_len_ff;
      stopped_in     = stopped_ff;
      module_addr_in = module_addr_ff;
      fin            = 1'b0;
      push_data      = '0;
      if (accept) begin
         if (req.start_of_info) begin
            word_offset_in = WORD_BYTES;
            total_in       = w;
            tag_begin_in   = FIRST_TAG;
            tag_code_in    = '0;
            tag_bytes_in   = '0;
            stride_in      = '0;
            entry_word_in  = '0;
            base_acc_in    = '0;
            length_acc_in  = '0;
            stored_in      = '0;
            name_len_in    = '0;
            stopped_in     = 1'b0;
            module_addr_in = '0;
            fin            = (w <= WORD_BYTES);
            active_in      = !fin;
         end else if (active_ff) begin
            tag_begin_in = advance ? tag_begin_ff + span[31:0] : tag_begin_ff;
            if (in_tag) begin
               if (rel == REL_TYPE) begin
                  tag_code_in   = w;
                  tag_bytes_in  = '0;
                  stride_in     = '0;
                  entry_word_in = '0;
                  name_len_in   = '0;
                  stopped_in    = 1'b0;
                  if (w == TAG_END) fin = 1'b1;
               end else if (rel == REL_SIZE) begin
                  tag_bytes_in = w;
                  if (w < MIN_TAG_BYTES) fin = 1'b1;
               end else if (in_body) begin
                  if (tag_code_ff == TAG_NAME) begin
                     name_len_in          = scan_len;
                     stopped_in           = scan_stop;
                     push_data.name_cnt   = scan_cnt;
                     push_data.name_chars = scan_chars;
                     push_data.name_pos   = name_len_ff;
                  end else if (tag_code_ff == TAG_BOOT_MODULE) begin
                     if (rel == REL_BODY && module_addr_ff == '0) module_addr_in = w;
                  end else if (tag_code_ff == TAG_MEMORY_MAP) begin
                     if (rel == REL_BODY) begin
                        stride_in = w;
                        if (w < MIN_STRIDE || w[1:0] != 2'b00) fin = 1'b1;
                     end else if (rel >= REL_ENTRIES) begin
                        unique case (entry_word_ff)
                           EW_BASE_LO: base_acc_in   = {32'd0, w};
                           EW_BASE_HI: base_acc_in   = {w, base_acc_ff[31:0]};
                           EW_LEN_LO:  length_acc_in = {32'd0, w};
                           EW_LEN_HI:  length_acc_in = {w, length_acc_ff[31:0]};
                           EW_TYPE: begin
                              // entry must fit inside its tag and the table
                              if (stored_ff < MAP_LIMIT &&
                                  {1'b0, rel} + ENTRY_TAIL <= {1'b0, tag_bytes_ff}) begin
                                 push_data.map_vld       = 1'b1;
                                 push_data.region_base   = base_acc_ff;
                                 push_data.region_length = length_acc_ff;
                                 push_data.mem_kind      = map_kind(w);
                                 push_data.entry_index   = stored_ff[4:0];
                                 stored_in               = stored_ff + 6'd1;
                              end
                           end
                           default: ;
                        endcase
                        entry_word_in = (entry_word_nx >= stride_ff) ? '0 : entry_word_nx;
                     end
                  end
               end
            end
            word_offset_in = next_off[31:0];
            if (!fin && next_off >= {1'b0, total_ff}) fin = 1'b1;
            active_in = !fin;
         end
      end
      push_data.fin         = fin;
      push_data.kernel_addr = module_addr_in;
      push_data.entry_count = stored_in;
      push = fin || push_data.map_vld || (push_data.name_cnt != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      word_offset_ff <= word_offset_in;
      total_ff       <= total_in;
      tag_begin_ff   <= tag_begin_in;
      tag_code_ff    <= tag_code_in;
      tag_bytes_ff   <= tag_bytes_in;
      stride_ff      <= stride_in;
      entry_word_ff  <= entry_word_in;
      base_acc_ff    <= base_acc_in;
      length_acc_ff  <= length_acc_in;
      stored_ff      <= stored_in;
      name_len_ff    <= name_len_in;
      stopped_ff     <= stopped_in;
      module_addr_ff <= module_addr_in;
   end

endmodule

`default_nettype wire

// ----- design/mb2_queue.sv -----
`default_nettype none

module mb2_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  mb2_pkg::batch_type push_data,
   output logic               full,
   input  wire logic          pop,
   output mb2_pkg::batch_type head,
   output logic               empty
);
   import mb2_pkg::*;

   batch_type             mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QUEUE_CW'(1);
         2'b01:   count_in = count_ff - QUEUE_CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue written while full");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- design/mb2_back.sv -----
`default_nettype none

module mb2_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  mb2_pkg::batch_type head,
   input  wire logic          empty,
   output logic               pop,
   mb2_rsp_if.source          rsp
);
   import mb2_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] region_base;
      logic [63:0] region_length;
      logic [2:0]  mem_kind;
      logic [4:0]  entry_index;
      logic [7:0]  name_char;
      logic [5:0]  name_pos;
      logic [31:0] kernel_addr;
      logic [5:0]  entry_count;
      logic        run_last;
   } result_type;

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   result_type  res_ff, res_in;
   logic [2:0]  n_main, n_total;
   logic        last, load;

   // names or one map entry first, finish last
   assign n_main  = head.name_cnt + {2'b00, head.map_vld};
   assign n_total = n_main + {2'b00, head.fin};
   assign last    = (idx_ff == n_total - 3'd1);
   assign load    = !empty && (!valid_ff || rsp.ready);
   assign pop     = load && last;

   always_comb begin
      res_in = '0;
      res_in.run_last = last;
      if (idx_ff < n_main) begin
         if (head.map_vld) begin
            res_in.kind          = KIND_MAP;
            res_in.region_base   = head.region_base;
            res_in.region_length = head.region_length;
            res_in.mem_kind      = head.mem_kind;
            res_in.entry_index   = head.entry_index;
         end else begin
            res_in.kind      = KIND_NAME;
            res_in.name_char = head.name_chars[idx_ff[1:0]];
            res_in.name_pos  = head.name_pos + 6'(idx_ff);
         end
      end else begin
         res_in.kind        = KIND_FINISH;
         res_in.kernel_addr = head.kernel_addr;
         res_in.entry_count = head.entry_count;
      end
   end

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last ? 3'd0 : idx_ff + 3'd1;
      end else begin
         valid_in = valid_ff && !rsp.ready;
         idx_in   = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.kind          = res_ff.kind;
   assign rsp.region_base   = res_ff.region_base;
   assign rsp.region_length = res_ff.region_length;
   assign rsp.mem_kind      = res_ff.mem_kind;
   assign rsp.entry_index   = res_ff.entry_index;
   assign rsp.name_char     = res_ff.name_char;
   assign rsp.name_pos      = res_ff.name_pos;
   assign rsp.kernel_addr   = res_ff.kernel_addr;
   assign rsp.entry_count   = res_ff.entry_count;
   assign rsp.run_last      = res_ff.run_last;

   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && res_ff.kind == KIND_FINISH |-> res_ff.run_last)
      else $error("finish item not marked last");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      !empty |-> idx_ff < n_total) else $error("result index past batch");

endmodule

`default_nettype wire

// ----- design/multiboot2_info_parser.sv -----
// Multiboot2 boot information parser. Takes the structure one 32-bit word per item on req_ch,
// the total-size word flagged by start_of_info, and delivers on rsp_ch one item per memory map
// entry, one per bootloader name byte, and a closing finish item carrying the first nonzero
// module address and the stored entry count; run_last marks the final item caused by a word.
// The parse front accepts one word every cycle unless the queue is full, and the result stage
// delivers one item every cycle while rsp_ch is ready; a word can cause up to five items, so
// a long name can fill the four-deep queue between the two and hold off req_ch until the
// result side catches up. Items pass from the queue through a result register to rsp_ch.
`default_nettype none

module multiboot2_info_parser #(
   parameter int MAX_MAP_ENTRIES = 32,
   parameter int NAME_MAX_BYTES  = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   mb2_req_if.sink   req_ch,
   mb2_rsp_if.source rsp_ch
);
   import mb2_pkg::*;

   logic      push, full, pop, empty;
   batch_type push_data, head;

   mb2_front #(
      .MAX_MAP_ENTRIES (MAX_MAP_ENTRIES),
      .NAME_MAX_BYTES  (NAME_MAX_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   mb2_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   mb2_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mb2_pkg::*;

   localparam int MAP_LIMIT    = 32;
   localparam int NAME_LIMIT   = 64;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int LONG_HOLD    = 60;
   localparam int RANDOM_ITEMS = 80;
   localparam int TAIL_CYCLES  = 20;

   // codes used only to build stimulus
   localparam logic [31:0] MT_RESERVED     = 32'd2;
   localparam logic [31:0] MT_ZERO         = 32'd0;
   localparam logic [31:0] TAG_FRAMEBUFFER = 32'd8;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] region_base;
      logic [63:0] region_length;
      logic [2:0]  mem_kind;
      logic [4:0]  entry_index;
      logic [7:0]  name_char;
      logic [5:0]  name_pos;
      logic [31:0] kernel_addr;
      logic [5:0]  entry_count;
      logic        run_last;
   } parse_result_type;

   logic clock = 1'b0;
   logic reset;

   mb2_req_if info_req ();
   mb2_rsp_if info_rsp ();

   multiboot2_info_parser #(
      .MAX_MAP_ENTRIES(MAP_LIMIT),
      .NAME_MAX_BYTES (NAME_LIMIT)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(info_req),
      .rsp_ch(info_rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser state as seen by the predictor
   logic [31:0] walk_offset, walk_total, tag_start, cur_tag_type, cur_tag_size;
   logic [31:0] map_stride, map_word, first_module;
   logic [63:0] map_base, map_length;
   logic [5:0]  map_count, name_count;
   logic        name_done, walking;

   parse_result_type word_items[$];
   parse_result_type pending_parse_items[$];
   parse_result_type head_item;
   logic [31:0]      info_body[$];

   int  error_count = 0;
   int  parsed_words = 0;
   int  ignored_words = 0;
   int  items_seen = 0;
   int  structures_sent = 0;
   int  cycle_count = 0;
   bit  sender_gaps_on = 1'b1;
   bit  sink_gaps_on = 1'b1;
   bit  long_hold_request = 1'b0;

   task automatic clear_parse_state();
      walk_offset  = '0;
      walk_total   = '0;
      tag_start    = FIRST_TAG;
      cur_tag_type = '0;
      cur_tag_size = '0;
      map_stride   = '0;
      map_word     = '0;
      first_module = '0;
      map_base     = '0;
      map_length   = '0;
      map_count    = '0;
      name_count   = '0;
      name_done    = 1'b0;
      walking      = 1'b0;
   endtask

   function automatic logic [2:0] region_kind(input logic [31:0] mem_type);
      case (mem_type)
         MT_AVAILABLE: return MK_AVAILABLE;
         MT_ACPI_RECL: return MK_ACPI_RECL;
         MT_ACPI_NVS:  return MK_ACPI_NVS;
         MT_BAD_RAM:   return MK_BAD_RAM;
         default:      return MK_RESERVED;
      endcase
   endfunction

   task automatic close_parse();
      parse_result_type r;
      r = '0;
      r.kind = KIND_FINISH;
      r.kernel_addr = first_module;
      r.entry_count = map_count;
      word_items.push_back(r);
      walking = 1'b0;
   endtask

   task automatic parse_info_word(input logic [31:0] w, input logic sof);
      logic [63:0]      rel, span, next_off;
      logic [7:0]       ch;
      parse_result_type r;
      int               b;
      word_items = {};
      if (sof) begin
         clear_parse_state();
         walk_total  = w;
         walk_offset = WORD_BYTES;
         walking     = 1'b1;
         if (w <= WORD_BYTES) close_parse();
      end else if (walking) begin
         if (walk_offset >= tag_start) begin
            rel  = {32'd0, walk_offset} - {32'd0, tag_start};
            span = ({32'd0, cur_tag_size} + {31'd0, ALIGN_MASK}) & ~{31'd0, ALIGN_MASK};
            if (rel >= REL_BODY && rel >= span) begin
               tag_start = tag_start + span[31:0];
               rel = {32'd0, walk_offset} - {32'd0, tag_start};
            end
            if (rel == REL_TYPE) begin
               cur_tag_type = w;
               cur_tag_size = '0;
               map_stride   = '0;
               map_word     = '0;
               name_count   = '0;
               name_done    = 1'b0;
               if (w == TAG_END) close_parse();
            end else if (rel == REL_SIZE) begin
               cur_tag_size = w;
               if (w < MIN_TAG_BYTES) close_parse();
            end else if (rel >= REL_BODY && rel < {32'd0, cur_tag_size}) begin
               if (cur_tag_type == TAG_NAME) begin
                  for (b = 0; b < 4 && !name_done && (rel + b) < {32'd0, cur_tag_size}; b++) begin
                     ch = w[8*b +: 8];
                     if (ch == 8'd0 || name_count >= NAME_LIMIT - 1) begin
                        name_done = 1'b1;
                     end else begin
                        r = '0;
                        r.kind = KIND_NAME;
                        r.name_char = ch;
                        r.name_pos = name_count;
                        word_items.push_back(r);
                        name_count = name_count + 6'd1;
                     end
                  end
               end else if (cur_tag_type == TAG_BOOT_MODULE) begin
                  if (rel == REL_BODY && first_module == '0) first_module = w;
               end else if (cur_tag_type == TAG_MEMORY_MAP) begin
                  if (rel == REL_BODY) begin
                     map_stride = w;
                     if (w < MIN_STRIDE || w[1:0] != 2'b00) close_parse();
                  end else if (rel >= REL_ENTRIES) begin
                     case (map_word)
                        EW_BASE_LO: map_base = {32'd0, w};
                        EW_BASE_HI: map_base = map_base | {w, 32'd0};
                        EW_LEN_LO:  map_length = {32'd0, w};
                        EW_LEN_HI:  map_length = map_length | {w, 32'd0};
                        EW_TYPE: begin
                           // entry kept only if it fits the tag and the table has room
                           if (map_count < MAP_LIMIT && rel + 64'd8 <= {32'd0, cur_tag_size}) begin
                              r = '0;
                              r.kind = KIND_MAP;
                              r.region_base = map_base;
                              r.region_length = map_length;
                              r.mem_kind = region_kind(w);
                              r.entry_index = map_count[4:0];
                              word_items.push_back(r);
                              map_count = map_count + 6'd1;
                           end
                        end
                        default: ;
                     endcase
                     map_word = map_word + WORD_BYTES;
                     if (map_word >= map_stride) map_word = '0;
                  end
               end
            end
         end
         next_off = {32'd0, walk_offset} + {32'd0, WORD_BYTES};
         walk_offset = next_off[31:0];
         if (walking && next_off >= {32'd0, walk_total}) close_parse();
      end
      if (word_items.size() > 0) begin
         r = word_items.pop_back();
         r.run_last = 1'b1;
         word_items.push_back(r);
      end
      foreach (word_items[i]) pending_parse_items.push_back(word_items[i]);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic send_word(input logic [31:0] w, input logic sof);
      int gap;
      gap = sender_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         info_req.valid <= 1'b0;
         info_req.data_word <= $urandom;
         info_req.start_of_info <= 1'($urandom_range(0, 1));
         repeat (gap) @(posedge clock);
      end
      info_req.valid <= 1'b1;
      info_req.data_word <= w;
      info_req.start_of_info <= sof;
      @(posedge clock);
      while (!info_req.ready) @(posedge clock);
      if (sof || walking) parsed_words++;
      else ignored_words++;
      parse_info_word(w, sof);
   endtask

   task automatic wait_for_results();
      info_req.valid <= 1'b0;
      while (pending_parse_items.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic pad_tag();
      while (info_body.size() % 2 != 0) info_body.push_back($urandom);
   endtask

   task automatic add_name_tag(input int len, input bit nul_ok);
      logic [31:0] w;
      logic [7:0]  ch;
      info_body.push_back(TAG_NAME);
      info_body.push_back(8 + len);
      for (int i = 0; i < (len + 3) / 4; i++) begin
         w = '0;
         for (int b = 0; b < 4; b++) begin
            ch = 8'($urandom_range(1, 255));
            if (nul_ok && $urandom_range(0, 29) == 0) ch = 8'd0;
            w[8*b +: 8] = ch;
         end
         info_body.push_back(w);
      end
      pad_tag();
   endtask

   task automatic add_module_tag();
      int tag_len;
      tag_len = 16 + $urandom_range(0, 9);
      info_body.push_back(TAG_BOOT_MODULE);
      info_body.push_back(tag_len);
      info_body.push_back(($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
      info_body.push_back($urandom);
      for (int i = 0; i < (tag_len - 16 + 3) / 4; i++) info_body.push_back($urandom);
      pad_tag();
   endtask

   function automatic logic [31:0] pick_map_type();
      case ($urandom_range(0, 6))
         0: return MT_AVAILABLE;
         1: return MT_RESERVED;
         2: return MT_ACPI_RECL;
         3: return MT_ACPI_NVS;
         4: return MT_BAD_RAM;
         5: return MT_ZERO;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_mmap_tag(input int entries, input bit allow_bad);
      int stride, tag_len, pos;
      case ($urandom_range(0, 5))
         0: stride = 28;
         1: stride = 32;
         2: stride = 40;
         default: stride = 24;
      endcase
      if (allow_bad && $urandom_range(0, 11) == 0) begin
         if ($urandom_range(0, 1) == 0) stride = 4 * $urandom_range(0, 5);
         else stride = 24 + $urandom_range(1, 3);
      end
      tag_len = 16 + entries * ((stride < 24) ? 24 : stride);
      // a short tag can cut the last entry off
      if ($urandom_range(0, 4) == 0) tag_len -= $urandom_range(1, 20);
      info_body.push_back(TAG_MEMORY_MAP);
      info_body.push_back(tag_len);
      info_body.push_back(stride);
      info_body.push_back($urandom);
      for (int i = 0; i < (tag_len - 16 + 3) / 4; i++) begin
         pos = (stride > 0) ? (4 * i) % stride : 0;
         if (pos == EW_TYPE) info_body.push_back(pick_map_type());
         else if (pos == EW_BASE_HI && $urandom_range(0, 3) == 0) info_body.push_back('1);
         else info_body.push_back($urandom);
      end
      pad_tag();
   endtask

   task automatic add_other_tag(input bit short_tag);
      logic [31:0] tag_code;
      int          tag_len;
      tag_code = $urandom;
      if ($urandom_range(0, 1) == 0) tag_code = $urandom_range(1, 21);
      if (tag_code == TAG_END || tag_code == TAG_NAME || tag_code == TAG_BOOT_MODULE ||
          tag_code == TAG_MEMORY_MAP)
         tag_code = TAG_FRAMEBUFFER;
      tag_len = short_tag ? $urandom_range(0, 7) : 8 + $urandom_range(0, 24);
      info_body.push_back(tag_code);
      info_body.push_back(tag_len);
      for (int i = 0; i < (tag_len - 8 + 3) / 4; i++) info_body.push_back($urandom);
      pad_tag();
   endtask

   // send the total-size word, the reserved word and the first body words
   task automatic send_info(input int total, input int body_words);
      send_word(total, 1'b1);
      send_word($urandom, 1'b0);
      for (int i = 0; i < body_words && (8 + 4 * i) < total + 4; i++)
         send_word(info_body[i], 1'b0);
      structures_sent++;
   endtask

   task automatic send_random_info(input bit big);
      int len_bytes, total, body_words;
      info_body = {};
      if (big) begin
         add_mmap_tag(MAP_LIMIT + 2, 1'b0);
         add_name_tag(NAME_LIMIT + 6, 1'b0);
      end else begin
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
               0, 1, 2: add_name_tag($urandom_range(1, 14), 1'b1);
               3, 4:    add_module_tag();
               5, 6, 7: add_mmap_tag($urandom_range(1, 4), 1'b1);
               8:       add_other_tag(1'b0);
               default: add_other_tag($urandom_range(0, 2) == 0);
            endcase
         end
      end
      len_bytes = 8 + 4 * info_body.size();
      if (big || $urandom_range(0, 3) != 0) begin
         info_body.push_back(TAG_END);
         info_body.push_back(MIN_TAG_BYTES);
         total = len_bytes + 8;
         if ($urandom_range(0, 4) == 0) total += $urandom_range(1, 64);
      end else begin
         total = $urandom_range(8, len_bytes);
      end
      body_words = info_body.size();
      // sometimes abandon the walk; the next start word restarts it
      if (!big && $urandom_range(0, 9) == 0) body_words = $urandom_range(0, body_words);
      send_info(total, body_words);
   endtask

   task automatic test_idle_and_tiny();
      send_word(32'h1234_5678, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0000_0000, 1'b1);
      send_word(32'h0000_0004, 1'b1);
      wait_for_results();
   endtask

   task automatic test_end_and_restart();
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFF0, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      send_word(TAG_END, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      wait_for_results();
   endtask

   task automatic test_short_tag();
      send_word(32'h0000_0040, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0007, 1'b0);
      wait_for_results();
   endtask

   task automatic test_boot_name();
      send_word(32'd40, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      // 13-byte tag: four bytes, then one byte before the tag ends
      send_word(TAG_NAME, 1'b0);
      send_word(32'd13, 1'b0);
      send_word(32'h0180_FF47, 1'b0);
      send_word(32'hAB00_CD7E, 1'b0);
      // NUL stops the name; the padding word hits the total size
      send_word(TAG_NAME, 1'b0);
      send_word(32'd12, 1'b0);
      send_word(32'h0041_4243, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      wait_for_results();
   endtask

   task automatic test_modules_and_map();
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      // zero module address is not kept
      send_word(TAG_BOOT_MODULE, 1'b0);
      send_word(32'd16, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0000_2000, 1'b0);
      send_word(TAG_BOOT_MODULE, 1'b0);
      send_word(32'd16, 1'b0);
      send_word(32'h0010_0000, 1'b0);
      send_word(32'h0020_0000, 1'b0);
      // second entry overruns the 60-byte tag
      send_word(TAG_MEMORY_MAP, 1'b0);
      send_word(32'd60, 1'b0);
      send_word(MIN_STRIDE, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      send_word(MT_BAD_RAM, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0009_F000, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0000_1000, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(MT_AVAILABLE, 1'b0);
      send_word(32'hDEAD_BEEF, 1'b0);
      send_word(TAG_END, 1'b0);
      wait_for_results();
   endtask

   task automatic test_bad_stride();
      send_word(32'h0000_0100, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      send_word(TAG_MEMORY_MAP, 1'b0);
      send_word(32'd40, 1'b0);
      send_word(32'd20, 1'b0);
      send_word(32'h0000_0100, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      send_word(TAG_MEMORY_MAP, 1'b0);
      send_word(32'd40, 1'b0);
      send_word(32'd26, 1'b0);
      wait_for_results();
   endtask

   task automatic test_full_tables();
      send_random_info(1'b1);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      sender_gaps_on = 1'b0;
      sink_gaps_on = 1'b0;
      long_hold_request = 1'b1;
      info_body = {};
      add_name_tag(40, 1'b0);
      info_body.push_back(TAG_END);
      info_body.push_back(MIN_TAG_BYTES);
      send_info(8 + 4 * info_body.size(), info_body.size());
      wait_for_results();
      sender_gaps_on = 1'b1;
      sink_gaps_on = 1'b1;
   endtask

   task automatic test_random_stream();
      int first_count;
      first_count = parsed_words;
      while (parsed_words - first_count < RANDOM_ITEMS) begin
         sender_gaps_on = ($urandom_range(0, 4) != 0);
         sink_gaps_on = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0);
         send_random_info(1'b0);
         if ($urandom_range(0, 9) == 0) wait_for_results();
      end
      sender_gaps_on = 1'b1;
      sink_gaps_on = 1'b1;
      wait_for_results();
   endtask

   // result side: random stalls plus one long hold on request
   initial begin : result_sink
      int g;
      int hold_left;
      hold_left = 0;
      info_rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            info_rsp.ready <= 1'b0;
         end else if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD;
            info_rsp.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            info_rsp.ready <= 1'b0;
         end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
            g = pick_gap();
            hold_left = (g > 0) ? g - 1 : 0;
            info_rsp.ready <= (g == 0);
         end else begin
            info_rsp.ready <= 1'b1;
         end
      end
   end

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && info_rsp.valid && info_rsp.ready) begin
         items_seen++;
         if (pending_parse_items.size() == 0) begin
            $display("%0t: unexpected item: expected none, actual kind %0d last %0b",
                     $time, info_rsp.kind, info_rsp.run_last);
            error_count++;
         end else begin
            head_item = pending_parse_items.pop_front();
            compare_field("kind", 64'(head_item.kind), 64'(info_rsp.kind));
            compare_field("region_base", head_item.region_base, info_rsp.region_base);
            compare_field("region_length", head_item.region_length, info_rsp.region_length);
            compare_field("mem_kind", 64'(head_item.mem_kind), 64'(info_rsp.mem_kind));
            compare_field("entry_index", 64'(head_item.entry_index),
                          64'(info_rsp.entry_index));
            compare_field("name_char", 64'(head_item.name_char), 64'(info_rsp.name_char));
            compare_field("name_pos", 64'(head_item.name_pos), 64'(info_rsp.name_pos));
            compare_field("kernel_addr", 64'(head_item.kernel_addr),
                          64'(info_rsp.kernel_addr));
            compare_field("entry_count", 64'(head_item.entry_count),
                          64'(info_rsp.entry_count));
            compare_field("run_last", 64'(head_item.run_last), 64'(info_rsp.run_last));
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout with %0d items outstanding", $time, pending_parse_items.size());
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      info_req.valid <= 1'b0;
      info_req.data_word <= '0;
      info_req.start_of_info <= 1'b0;
      reset <= 1'b1;
      clear_parse_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_tiny();
      test_end_and_restart();
      test_short_tag();
      test_boot_name();
      test_modules_and_map();
      test_bad_stride();
      test_full_tables();
      test_backpressure();
      test_random_stream();

      if (pending_parse_items.size() != 0) begin
         $display("%0t: %0d items never arrived", $time, pending_parse_items.size());
         error_count++;
      end
      $display("Sent %0d structures: %0d words parsed, %0d words ignored while idle",
               structures_sent, parsed_words, ignored_words);
      $display("Checked %0d result items in %0d cycles", items_seen, cycle_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
design/mb2_pkg.sv
design/mb2_req_if.sv
design/mb2_rsp_if.sv
design/mb2_front.sv
design/mb2_queue.sv
design/mb2_back.sv
design/multiboot2_info_parser.sv
tb/sv/tb_top.sv
